@@ rtl/core/switch_press_click_qualifier_defines.svh @@
// Assertion macros for the switch press/click qualifier.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SWITCH_PRESS_CLICK_QUALIFIER_DEFINES_SVH
`define SWITCH_PRESS_CLICK_QUALIFIER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SPCQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SPCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/spcq_pkg.sv @@
// Shared types and constants for the switch press/click qualifier.
// No dependencies.
package spcq_pkg;

  localparam int unsigned NUM_SWITCHES_DEF = 2;
  localparam int unsigned CNT_W            = 16;
  localparam logic [CNT_W-1:0] HOLD_RESET  = 16'd70;
  localparam logic [CNT_W-1:0] IDLE_MARK   = 16'hFFFF;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_PUSH  = 2'd1,
    ST_CLICK = 2'd2
  } status_t;

  // Per-lane result of one step
  typedef struct packed {
    status_t status;
    logic    match;
  } lane_res_t;

  // One result item
  typedef struct packed {
    logic [1:0] status_next;
    logic [1:0] status_exe;
    logic       matched;
  } out_item_t;

endpackage

@@ rtl/core/spcq_lane.sv @@
// One switch lane: hold counter, status and previous status.
// Depends on spcq_pkg.
module spcq_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        kind,
  input  logic                        pin,
  input  logic                        sel_hit,
  input  logic [1:0]                  asked_status,
  input  logic [spcq_pkg::CNT_W-1:0]  hold_ticks,
  output spcq_pkg::lane_res_t         res
);
  import spcq_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  status_t          st_r, st_nxt;
  status_t          prev_r, prev_nxt;

  logic [CNT_W-1:0] cnt_run;
  status_t          st_tick;
  logic             hit;

  always_comb begin
    cnt_run = cnt_r;
    st_tick = st_r;
    if (pin == 1'b0) begin
      // pressed: arm counter on first tick, declare push at zero
      cnt_run = (cnt_r == IDLE_MARK) ? hold_ticks : cnt_r;
      if (cnt_run == '0) begin
        st_tick = ST_PUSH;
      end
    end else begin
      cnt_run = IDLE_MARK;
      st_tick = (prev_r == ST_PUSH) ? ST_CLICK : ST_NONE;
    end
  end

  assign hit = sel_hit && (st_r == status_t'(asked_status));

  always_comb begin
    cnt_nxt  = cnt_r;
    st_nxt   = st_r;
    prev_nxt = prev_r;
    if (step) begin
      if (kind == KIND_TICK) begin
        st_nxt   = st_tick;
        prev_nxt = st_tick;
        cnt_nxt  = (cnt_run != '0 && cnt_run != IDLE_MARK) ? cnt_run - 1'b1 : cnt_run;
      end else if (hit && st_r == ST_CLICK) begin
        // read-once click; previous status keeps click
        st_nxt = ST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= IDLE_MARK;
      st_r   <= ST_NONE;
      prev_r <= ST_NONE;
    end else begin
      cnt_r  <= cnt_nxt;
      st_r   <= st_nxt;
      prev_r <= prev_nxt;
    end
  end

  assign res.status = st_nxt;
  assign res.match  = (kind == KIND_QUERY) && hit;

endmodule

@@ rtl/core/spcq_merge.sv @@
// Merge stage: combines lane results into one result item.
// Depends on spcq_pkg.
module spcq_merge #(
  parameter int unsigned NUM_SWITCHES = spcq_pkg::NUM_SWITCHES_DEF
) (
  input  spcq_pkg::lane_res_t lane_res [NUM_SWITCHES],
  output spcq_pkg::out_item_t item
);
  import spcq_pkg::*;

  logic any_match;

  always_comb begin
    any_match = 1'b0;
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      any_match = any_match | lane_res[i].match;
    end
  end

  assign item.status_next = lane_res[0].status;
  assign item.matched     = any_match;

  generate
    if (NUM_SWITCHES >= 2) begin : g_exe
      assign item.status_exe = lane_res[1].status;
    end else begin : g_no_exe
      assign item.status_exe = ST_NONE;
    end
  endgenerate

endmodule

@@ rtl/core/spcq_skid.sv @@
// Output register with skid stage; stall toward the source is registered.
// Depends on spcq_pkg.
module spcq_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  spcq_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output spcq_pkg::out_item_t out_item
);
  import spcq_pkg::*;

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      take;

  assign take = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (push) begin
      if (main_v_r && !take) begin
        // park the transfer behind the waiting result
        skid_nxt   = push_item;
        skid_v_nxt = 1'b1;
      end else begin
        main_nxt   = push_item;
        main_v_nxt = 1'b1;
      end
    end else if (take) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_item  = main_r;

endmodule

@@ rtl/core/switch_press_click_qualifier.sv @@
// Switch press/click qualifier: one lane per switch, merged into one result.
// Each input transfer's result is registered in the output buffer.
// Throughput: one item per cycle unless stalled; a two-entry output buffer
// keeps input open while one result waits; stall rises only once both are full.
// Reset (synchronous, rst_n low): counters idle, statuses none, hold_ticks 70.
// Configuration writes are always ready; a write of 0xFFFF stores 0xFFFE.
`include "switch_press_click_qualifier_defines.svh"

module switch_press_click_qualifier #(
  parameter int unsigned NUM_SWITCHES = spcq_pkg::NUM_SWITCHES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [1:0]  in_pin_levels,
  input  logic        in_switch_sel,
  input  logic [1:0]  in_asked_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status_next,
  output logic [1:0]  out_status_exe,
  output logic        out_matched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import spcq_pkg::*;

  logic [CNT_W-1:0] hold_ticks_r, hold_ticks_nxt;
  logic             step;
  logic             buf_full;
  lane_res_t        lane_res [NUM_SWITCHES];
  out_item_t        res_item;
  out_item_t        out_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    hold_ticks_nxt = hold_ticks_r;
    if (cfg_valid && cfg_ready) begin
      // keep a loaded threshold distinct from the idle marker
      hold_ticks_nxt = (cfg_data == IDLE_MARK) ? IDLE_MARK - 1'b1 : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_RESET;
    end else begin
      hold_ticks_r <= hold_ticks_nxt;
    end
  end

  assign in_stall = buf_full;
  assign step     = in_valid && !in_stall;

  generate
    for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_lane
      logic pin;
      logic sel_hit;
      if (i < 2) begin : g_pin
        assign pin     = in_pin_levels[i];
        assign sel_hit = (in_switch_sel == 1'(i));
      end else begin : g_nopin
        // no pin bit: reads as pressed; never selectable by a query
        assign pin     = 1'b0;
        assign sel_hit = 1'b0;
      end
      spcq_lane u_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .kind         (in_kind),
        .pin          (pin),
        .sel_hit      (sel_hit),
        .asked_status (in_asked_status),
        .hold_ticks   (hold_ticks_r),
        .res          (lane_res[i])
      );
    end
  endgenerate

  spcq_merge #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_merge (
    .lane_res (lane_res),
    .item     (res_item)
  );

  spcq_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_item (res_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_status_next = out_item.status_next;
  assign out_status_exe  = out_item.status_exe;
  assign out_matched     = out_item.matched;

  `SPCQ_ASSERT_SAME(a_stall_needs_result, in_stall, out_valid, "stall without held result")
  `SPCQ_ASSERT_SAME(a_tick_no_match, step && in_kind == KIND_TICK, !res_item.matched, "tick matched")
  `SPCQ_ASSERT_SAME(a_code3_no_match, step && in_asked_status == 2'd3, !res_item.matched,
                    "asked status three matched")
  `SPCQ_ASSERT_NEXT(a_hold_not_idle, 1'b1, hold_ticks_r != IDLE_MARK, "threshold equals idle marker")

endmodule
